>>> rtl/mat4_vector_transform_unit_assert.svh
// Assertion macros used by the RTL of the matrix transform unit.
// Each macro expands to nothing when SYNTHESIS is defined.
`ifndef MAT4_VECTOR_TRANSFORM_UNIT_ASSERT_SVH
`define MAT4_VECTOR_TRANSFORM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MVT_CHECK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MVT_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MVT_CHECK(lbl, clk, rstn, prop, msg)
`define MVT_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/mvt_pkg.sv
`timescale 1ns / 1ps
package mvt_pkg;
	localparam int DIM = 4;
	localparam int FRAC_BITS = 16;
	localparam int NVEC = 4;
	localparam int DATA_W = 32;
	localparam int ROW_W = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int IDX_W = (ROW_W > 2) ? ROW_W : 2;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W = PROD_W + $clog2(DIM);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_XFORM = 1'b1
	} op_t;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		op_t op;
		logic [1:0] row_index;
		logic [1:0] col_index;
		word_t coef_value;
		word_t vec_x;
		word_t vec_y;
		word_t vec_z;
		word_t vec_w;
	} in_item_t;

	typedef struct packed {
		word_t out_x;
		word_t out_y;
		word_t out_z;
		word_t out_w;
	} out_item_t;

	// Token handed from one column cell to the next.
	typedef struct packed {
		logic valid;
		op_t op;
		logic [1:0] row_index;
		logic [1:0] col_index;
		word_t coef_value;
		word_t [NVEC-1:0] vec;
		logic [DIM-1:0][ACC_W-1:0] acc;
	} cell_bus_t;
endpackage

>>> rtl/mvt_in_if.sv
`timescale 1ns / 1ps
interface mvt_in_if;
	import mvt_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/mvt_out_if.sv
`timescale 1ns / 1ps
interface mvt_out_if;
	import mvt_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/mat4_vector_transform_unit.sv
`timescale 1ns / 1ps
// Multiplies a stored 4x4 signed Q16.16 matrix by a stream of vectors. A transfer with
// op LOAD writes one coefficient (row, column) and returns nothing; a transfer with op
// XFORM returns the four row dot products, rounded half up to Q16.16 and saturated to
// 32 bits. The matrix is zero after reset. One item is taken every cycle unless the
// result side stalls the chain, loads and transforms mixed freely. The vector walks a
// chain of DIM column cells, each holding one matrix column, with a register after its
// per-row multipliers and one after the running sums, followed by one rounding and
// output register. A load travels the same chain, so every transform sees exactly the
// loads that were transferred before it.
module mat4_vector_transform_unit (
	input logic clk,
	input logic arst_n,
	mvt_in_if.sink item,
	mvt_out_if.source result
);
	import mvt_pkg::*;

	cell_bus_t head_bus;
	cell_bus_t bus [DIM+1];
	logic adv [DIM+1];

	always_comb begin
		head_bus = '0;
		head_bus.valid = item.valid;
		head_bus.op = item.data.op;
		head_bus.row_index = item.data.row_index;
		head_bus.col_index = item.data.col_index;
		head_bus.coef_value = item.data.coef_value;
		head_bus.vec[0] = item.data.vec_x;
		head_bus.vec[1] = item.data.vec_y;
		head_bus.vec[2] = item.data.vec_z;
		head_bus.vec[3] = item.data.vec_w;
	end

	assign bus[0] = head_bus;
	assign item.ready = adv[0];

	for (genvar c = 0; c < DIM; c++) begin : g_cell
		mvt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.col_id(IDX_W'(c)),
			.up(bus[c]),
			.up_adv(adv[c]),
			.dn(bus[c + 1]),
			.dn_adv(adv[c + 1])
		);
	end

	mvt_round u_round (
		.clk(clk),
		.arst_n(arst_n),
		.up(bus[DIM]),
		.up_adv(adv[DIM]),
		.result(result)
	);
endmodule

>>> rtl/mvt_cell.sv
`timescale 1ns / 1ps
module mvt_cell (
	input logic clk,
	input logic arst_n,
	input logic [mvt_pkg::IDX_W-1:0] col_id,
	input mvt_pkg::cell_bus_t up,
	output logic up_adv,
	output mvt_pkg::cell_bus_t dn,
	input logic dn_adv
);
	import mvt_pkg::*;
	`include "mat4_vector_transform_unit_assert.svh"

	logic [DIM-1:0][DATA_W-1:0] coef_q;
	logic v_s1;
	logic v_s2;
	cell_bus_t bus_s1;
	cell_bus_t bus_s2;
	cell_bus_t nxt_s2;
	logic signed [PROD_W-1:0] prod_s1 [DIM];
	logic adv_s1;
	logic adv_s2;
	logic ld_hit;
	logic [IDX_W-1:0] ld_row;

	assign adv_s2 = !v_s2 || dn_adv;
	assign adv_s1 = !v_s1 || adv_s2;
	assign up_adv = adv_s1;

	assign ld_row = IDX_W'(up.row_index);
	assign ld_hit = adv_s1 && up.valid && (up.op == OP_LOAD)
		&& (IDX_W'(up.col_index) == col_id) && (int'(ld_row) < DIM);

	// This cell owns one column; a load for it is applied as the token enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ld_hit) begin
			coef_q[ld_row[ROW_W-1:0]] <= up.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= up.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bus_s1 <= up;
			for (int r = 0; r < DIM; r++) begin
				prod_s1[r] <= $signed(coef_q[r]) * $signed(up.vec[0]);
			end
		end
	end

	// The consumed element leaves the vector so the next cell finds its own at the head.
	always_comb begin
		nxt_s2 = bus_s1;
		nxt_s2.valid = v_s1;
		for (int i = 0; i < NVEC - 1; i++) begin
			nxt_s2.vec[i] = bus_s1.vec[i + 1];
		end
		nxt_s2.vec[NVEC-1] = '0;
		for (int r = 0; r < DIM; r++) begin
			nxt_s2.acc[r] = bus_s1.acc[r] + ACC_W'(prod_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			bus_s2 <= nxt_s2;
		end
	end

	always_comb begin
		dn = bus_s2;
		dn.valid = v_s2;
	end

	`MVT_CHECK(a_stall_back, clk, arst_n, (v_s1 && v_s2 && !dn_adv) |-> !up_adv, "stall did not reach the upstream side")
	`MVT_CHECK_NEXT(a_coef_write, clk, arst_n, ld_hit, coef_q[$past(ld_row[ROW_W-1:0])] == $past(up.coef_value), "coefficient load lost")
	`MVT_CHECK_NEXT(a_coef_hold, clk, arst_n, !ld_hit, $stable(coef_q), "coefficient changed without a load")
	`MVT_CHECK_NEXT(a_s2_hold, clk, arst_n, v_s2 && !dn_adv, v_s2 && $stable(bus_s2), "stalled token changed")
endmodule

>>> rtl/mvt_round.sv
`timescale 1ns / 1ps
module mvt_round (
	input logic clk,
	input logic arst_n,
	input mvt_pkg::cell_bus_t up,
	output logic up_adv,
	mvt_out_if.source result
);
	import mvt_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

	logic out_v_q;
	out_item_t out_q;
	logic adv;
	word_t res [NVEC];

	function automatic word_t round_sat(input logic [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] q;
		word_t r;
		sum = $signed(acc) + HALF;
		q = sum >>> FRAC_BITS;
		priority if (q > SAT_HI) begin
			r = SAT_HI[DATA_W-1:0];
		end else if (q < SAT_LO) begin
			r = SAT_LO[DATA_W-1:0];
		end else begin
			r = q[DATA_W-1:0];
		end
		return r;
	endfunction

	for (genvar r = 0; r < NVEC; r++) begin : g_row
		if (r < DIM) begin : g_live
			assign res[r] = round_sat(up.acc[r]);
		end else begin : g_zero
			assign res[r] = '0;
		end
	end

	assign adv = !out_v_q || result.ready;
	assign up_adv = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= up.valid && (up.op == OP_XFORM);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_x <= res[0];
			out_q.out_y <= res[1];
			out_q.out_z <= res[2];
			out_q.out_w <= res[3];
		end
	end

	assign result.valid = out_v_q;
	assign result.data = out_q;
endmodule

>>> tb/mvt_checker.sv
`timescale 1ns / 1ps
module mvt_checker
	import mvt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input in_item_t item_data,
	input logic result_valid,
	input logic result_ready,
	input out_item_t result_data,
	output int mismatches,
	output int pending,
	output int results_seen,
	output int loads_seen
);
	localparam int SUM_W = PROD_W + 8;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 72'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -72'sh8000_0000;
	localparam logic signed [SUM_W-1:0] HALF_LSB = 72'sd1 <<< (FRAC_BITS - 1);

	// Coefficients are kept column-major, indexed as [column][row].
	word_t coef [DIM][DIM];
	out_item_t products_q [$];

	function automatic out_item_t transform_vec(input in_item_t it);
		word_t v [4];
		word_t r [4];
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] a;
		logic signed [SUM_W-1:0] b;
		v = '{it.vec_x, it.vec_y, it.vec_z, it.vec_w};
		for (int row = 0; row < 4; row++) begin
			r[row] = '0;
			if (row < DIM) begin
				sum = '0;
				for (int c = 0; c < 4; c++) begin
					if (c < DIM) begin
						a = coef[c][row];
						b = v[c];
						sum = sum + a * b;
					end
				end
				sum = (sum + HALF_LSB) >>> FRAC_BITS;
				if (sum > SUM_MAX)
					sum = SUM_MAX;
				else if (sum < SUM_MIN)
					sum = SUM_MIN;
				r[row] = sum[DATA_W-1:0];
			end
		end
		return '{r[0], r[1], r[2], r[3]};
	endfunction

	function automatic int compare_word(input string name, input word_t want, input word_t got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int bad;
		if (!arst_n) begin
			for (int c = 0; c < DIM; c++)
				for (int row = 0; row < DIM; row++)
					coef[c][row] = '0;
			products_q.delete();
			mismatches <= 0;
			pending <= 0;
			results_seen <= 0;
			loads_seen <= 0;
		end else begin
			bad = 0;
			if (item_valid && item_ready) begin
				if (item_data.op == OP_LOAD) begin
					if (item_data.row_index < DIM && item_data.col_index < DIM)
						coef[item_data.col_index][item_data.row_index] = item_data.coef_value;
					loads_seen <= loads_seen + 1;
				end else begin
					products_q.push_back(transform_vec(item_data));
				end
			end
			if (result_valid && result_ready) begin
				if (products_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						result_data);
					bad++;
				end else begin
					want = products_q.pop_front();
					bad += compare_word("out_x", want.out_x, result_data.out_x);
					bad += compare_word("out_y", want.out_y, result_data.out_y);
					bad += compare_word("out_z", want.out_z, result_data.out_z);
					bad += compare_word("out_w", want.out_w, result_data.out_w);
				end
				results_seen <= results_seen + 1;
			end
			mismatches <= mismatches + bad;
			pending <= products_q.size();
		end
	end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import mvt_pkg::*;

	localparam word_t W_MAX = 32'sh7FFF_FFFF;
	localparam word_t W_MIN = 32'sh8000_0000;
	localparam word_t ONE = 32'sh0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int idle_pct = 0;
	bit long_hold_done = 1'b0;
	int sent = 0;
	int mismatches;
	int pending;
	int results_seen;
	int loads_seen;

	mvt_in_if item_ch ();
	mvt_out_if result_ch ();

	always #6 clk = ~clk;

	mat4_vector_transform_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	mvt_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_ch.valid),
		.item_ready(item_ch.ready),
		.item_data(item_ch.data),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_data(result_ch.data),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.loads_seen(loads_seen)
	);

	function automatic word_t rand_word();
		int v;
		case ($urandom_range(0, 4))
			0: return word_t'($urandom);
			1: begin
				v = $urandom_range(0, 2097151);
				return word_t'(v - 1048576);
			end
			2: begin
				case ($urandom_range(0, 4))
					0: return W_MAX;
					1: return W_MIN;
					2: return '0;
					3: return ONE;
					default: return -ONE;
				endcase
			end
			3: return word_t'($urandom_range(0, 65535));
			default: return word_t'($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_item(input in_item_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic load_coef(input logic [1:0] row, input logic [1:0] col, input word_t v);
		in_item_t it;
		it.op = OP_LOAD;
		it.row_index = row;
		it.col_index = col;
		it.coef_value = v;
		it.vec_x = word_t'($urandom);
		it.vec_y = word_t'($urandom);
		it.vec_z = word_t'($urandom);
		it.vec_w = word_t'($urandom);
		send_item(it);
	endtask

	task automatic push_vector(input word_t x, input word_t y, input word_t z, input word_t w);
		in_item_t it;
		it.op = OP_XFORM;
		it.row_index = 2'($urandom);
		it.col_index = 2'($urandom);
		it.coef_value = word_t'($urandom);
		it.vec_x = x;
		it.vec_y = y;
		it.vec_z = z;
		it.vec_w = w;
		send_item(it);
	endtask

	initial begin : receiver
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!long_hold_done && results_seen >= 40) begin
				result_ch.ready <= 1'b0;
				repeat (120) @(negedge clk);
				long_hold_done = 1'b1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int chunk;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The matrix is still zero, so even extreme vectors give zero.
		push_vector(W_MAX, W_MIN, ONE, -ONE);
		for (int i = 0; i < 4; i++)
			load_coef(2'(i), 2'(i), ONE);
		push_vector(W_MAX, W_MIN, 32'sh0000_8000, -ONE);
		for (int c = 0; c < 4; c++)
			load_coef(2'd0, 2'(c), W_MAX);
		push_vector(W_MAX, W_MAX, W_MAX, W_MAX);
		push_vector(W_MIN, W_MIN, W_MIN, W_MIN);
		load_coef(2'd3, 2'd3, W_MIN);
		push_vector('0, '0, '0, W_MIN);
		// A tiny coefficient exposes rounding of exact ties and of values just below them.
		load_coef(2'd1, 2'd1, 32'sd1);
		push_vector('0, 32'sh0000_8000, '0, '0);
		push_vector('0, -32'sh0000_8000, '0, '0);
		push_vector('0, 32'sh0000_7FFF, '0, '0);
		load_coef(2'd2, 2'd1, -ONE);
		load_coef(2'd1, 2'd2, 32'sh0002_8000);
		push_vector(ONE, -ONE, ONE, 32'sh0000_4000);

		for (int i = 0; i < 1230; i++) begin
			chunk = i / 100;
			idle_pct = (i >= 1000 || chunk % 3 == 1) ? 0 : 30;
			if ($urandom_range(0, 99) < 30)
				load_coef(2'($urandom), 2'($urandom), rand_word());
			else
				push_vector(rand_word(), rand_word(), rand_word(), rand_word());
		end
		item_ch.valid <= 1'b0;
	end

	initial begin : verdict
		wait (sent == 1251);
		for (int k = 0; k < 5000 && pending != 0; k++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d transfers: %0d coefficient loads and %0d checked transforms.",
			sent, loads_seen, results_seen);
		$display("Covered ties, saturation both ways, gaps on both sides and a long output stall.");
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2_400_000;
		$display("FAIL");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/mvt_pkg.sv
rtl/mvt_in_if.sv
rtl/mvt_out_if.sv
rtl/mvt_cell.sv
rtl/mvt_round.sv
rtl/mat4_vector_transform_unit.sv
tb/mvt_checker.sv
tb/testbench.sv
